/* sv/sdfcsg_pkg.sv */
package sdfcsg_pkg;

    // Blend width register width and reset (1.0 in Q16.16)
    localparam int K_BITS = 31;
    localparam logic [K_BITS-1:0] K_RESET = 31'd65536;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;
    localparam int OP_W       = 3;

    localparam logic [CFG_IDX_W-1:0] REG_COMBINE_OP = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_K   = 4'd1;

    typedef enum logic [OP_W-1:0] {
        OP_INTERSECT         = 3'd0,
        OP_UNION             = 3'd1,
        OP_DIFFERENCE        = 3'd2,
        OP_SMOOTH_INTERSECT  = 3'd3,
        OP_SMOOTH_UNION      = 3'd4,
        OP_SMOOTH_DIFFERENCE = 3'd5
    } combine_op_t;

endpackage

/* sv/sdf_csg_smooth_combiner_core.sv */
// Smooth CSG combiner: merges two signed distances into one, Q(WORD_BITS-FRAC_BITS).FRAC_BITS.
//
// Channels:
//   s_*   : input pair (s_dist_a, s_dist_b), valid/ready, transfer when both high.
//   m_*   : combined distance m_dist_out, valid/ready, transfer when both high.
//   cfg_* : register writes, always ready. Index 0 selects the operation,
//           index 1 the blend width k (zero acts as one). Other indexes are ignored.
//           Write only while no item is in flight.
// Pipeline:
//   Two setup stages, a restoring divider for t = |e|/(2k) that resolves one
//   quotient bit per stage (FRAC_BITS-1 stages), then three multiply/add
//   stages and the saturating output register.
//   Throughput is one pair per cycle while the output is not stalled.
// Stall: when the result register is full and m_ready is low the whole pipeline
//   holds and s_ready drops; nothing is lost or repeated.
// Reset: aresetn (synchronous, active low) empties the pipeline and sets
//   the operation to hard intersect and k to 1.0 in Q16.16.
module sdf_csg_smooth_combiner_core #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [sdfcsg_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [sdfcsg_pkg::CFG_DATA_W-1:0]     cfg_data,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [WORD_BITS-1:0]           s_dist_a,
    input  logic signed [WORD_BITS-1:0]           s_dist_b,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [WORD_BITS-1:0]           m_dist_out
);
    import sdfcsg_pkg::*;

    localparam int W   = WORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int XW  = W + 1;
    localparam int EW  = W + 2;
    localparam int CW  = (EW > K_BITS + 1) ? EW : K_BITS + 1;
    localparam int RW  = K_BITS + 1;
    localparam int QW  = F - 1;
    localparam int DIV_STAGES = QW;
    localparam int HW  = F + 1;
    localparam int DW  = W + 2;
    localparam int PW  = DW + HW + 1;
    localparam int PBW = F - 1;
    localparam int KPW = K_BITS + PBW;
    localparam int BW  = KPW - F;
    localparam int SW  = ((DW > BW + 1) ? DW : BW + 1) + 1;

    localparam logic [HW-1:0] ONE_H  = {1'b1, {F{1'b0}}};
    localparam logic [HW-1:0] HALF_H = {2'b01, {(F-1){1'b0}}};
    localparam logic signed [SW-1:0] SAT_MAX = $signed({{(SW-W+1){1'b0}}, {(W-1){1'b1}}});
    localparam logic signed [SW-1:0] SAT_MIN = ~SAT_MAX;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [XW-1:0] v;
        logic                 blend;
        logic                 add_bump;
        logic                 e_neg;
    } carry_t;

    // ---------------- configuration ----------------
    combine_op_t       op_reg, op_next;
    logic [K_BITS-1:0] k_reg, k_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        op_next = op_reg;
        k_next  = k_reg;
        if (cfg_valid) begin
            if (cfg_addr == REG_COMBINE_OP) begin
                op_next = combine_op_t'(cfg_data[OP_W-1:0]);
            end else if (cfg_addr == REG_SMOOTH_K) begin
                // zero width behaves as the smallest step
                k_next = (cfg_data[K_BITS-1:0] == '0) ? K_BITS'(1) : cfg_data[K_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg <= OP_INTERSECT;
            k_reg  <= K_RESET;
        end else begin
            op_reg <= op_next;
            k_reg  <= k_next;
        end
    end

    // ---------------- pipeline control ----------------
    logic                  en;
    logic                  s1_vld_reg, s2_vld_reg, sh_vld_reg, sm_vld_reg, sn_vld_reg;
    logic                  out_vld_reg;
    logic [DIV_STAGES-1:0] div_vld_reg;

    assign en      = !out_vld_reg || m_ready;
    assign s_ready = en;
    assign m_valid = out_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            div_vld_reg <= '0;
            sh_vld_reg  <= 1'b0;
            sm_vld_reg  <= 1'b0;
            sn_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            s1_vld_reg  <= s_valid;
            s2_vld_reg  <= s1_vld_reg;
            div_vld_reg <= {div_vld_reg[DIV_STAGES-2:0], s2_vld_reg};
            sh_vld_reg  <= div_vld_reg[DIV_STAGES-1];
            sm_vld_reg  <= sh_vld_reg;
            sn_vld_reg  <= sm_vld_reg;
            out_vld_reg <= sn_vld_reg;
        end
    end

    // ---------------- stage 1: operands, hard result ----------------
    logic signed [XW-1:0] a_x, b_x, nb_x;
    logic signed [EW-1:0] ea, eb, enb;
    logic signed [XW-1:0] s1_x_reg, s1_x_next, s1_y_reg, s1_y_next, s1_v_reg, s1_v_next;
    logic signed [EW-1:0] s1_e_reg, s1_e_next;
    logic                 s1_smooth_reg, s1_smooth_next, s1_add_reg, s1_add_next;

    assign a_x  = XW'(s_dist_a);
    assign b_x  = XW'(s_dist_b);
    assign nb_x = -b_x;
    assign ea   = EW'(a_x);
    assign eb   = EW'(b_x);
    assign enb  = EW'(nb_x);

    always_comb begin
        s1_x_next      = a_x;
        s1_y_next      = b_x;
        s1_v_next      = (a_x > b_x) ? a_x : b_x;
        s1_e_next      = eb - ea;
        s1_smooth_next = 1'b0;
        s1_add_next    = 1'b1;
        unique case (op_reg)
            OP_UNION: begin
                s1_v_next = (a_x < b_x) ? a_x : b_x;
            end
            OP_DIFFERENCE: begin
                s1_v_next = (a_x > nb_x) ? a_x : nb_x;
            end
            OP_SMOOTH_INTERSECT: begin
                s1_smooth_next = 1'b1;
            end
            OP_SMOOTH_UNION: begin
                s1_smooth_next = 1'b1;
                s1_add_next    = 1'b0;
                s1_e_next      = ea - eb;
            end
            OP_SMOOTH_DIFFERENCE: begin
                s1_smooth_next = 1'b1;
                s1_y_next      = nb_x;
                s1_e_next      = enb - ea;
            end
            default: begin
                // intersect, and the unused codes
                s1_smooth_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_x_reg      <= s1_x_next;
            s1_y_reg      <= s1_y_next;
            s1_v_reg      <= s1_v_next;
            s1_e_reg      <= s1_e_next;
            s1_smooth_reg <= s1_smooth_next;
            s1_add_reg    <= s1_add_next;
        end
    end

    // ---------------- stage 2: clamp test, |e| ----------------
    logic signed [CW-1:0] e_c, k_c, mag_c;
    logic                 e_ge_k, e_le_nk;
    logic [K_BITS-1:0]    s2_mag_reg, s2_mag_next;
    carry_t               s2_car_reg, s2_car_next;

    assign e_c     = CW'(s1_e_reg);
    assign k_c     = $signed(CW'(k_reg));
    assign e_ge_k  = e_c >= k_c;
    assign e_le_nk = e_c <= -k_c;
    assign mag_c   = e_c[CW-1] ? -e_c : e_c;

    always_comb begin
        s2_mag_next          = mag_c[K_BITS-1:0];
        s2_car_next.x        = s1_x_reg;
        s2_car_next.y        = s1_y_reg;
        s2_car_next.blend    = s1_smooth_reg && !e_ge_k && !e_le_nk;
        s2_car_next.add_bump = s1_add_reg;
        s2_car_next.e_neg    = s1_e_reg[EW-1];
        if (!s1_smooth_reg) begin
            s2_car_next.v = s1_v_reg;
        end else if (e_ge_k) begin
            s2_car_next.v = s1_y_reg;
        end else begin
            s2_car_next.v = s1_x_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_mag_reg <= s2_mag_next;
            s2_car_reg <= s2_car_next;
        end
    end

    // ---------------- divider: t = floor(|e| * 2^(F-1) / k), one bit per stage ----------------
    logic [RW-1:0] div_rem_reg [DIV_STAGES];
    logic [QW-1:0] div_quo_reg [DIV_STAGES];
    carry_t        div_car_reg [DIV_STAGES];

    for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
        logic [RW-1:0] rem_in, rem_dbl, rem_next;
        logic [QW-1:0] quo_in, quo_next;
        carry_t        car_in;
        logic          fits;

        if (i == 0) begin : g_first
            assign rem_in = {1'b0, s2_mag_reg};
            assign quo_in = '0;
            assign car_in = s2_car_reg;
        end else begin : g_rest
            assign rem_in = div_rem_reg[i-1];
            assign quo_in = div_quo_reg[i-1];
            assign car_in = div_car_reg[i-1];
        end

        // when blending the remainder stays below k, so doubling never overflows RW bits
        assign rem_dbl  = {rem_in[RW-2:0], 1'b0};
        assign fits     = rem_dbl >= RW'(k_reg);
        assign rem_next = fits ? rem_dbl - RW'(k_reg) : rem_dbl;
        assign quo_next = {quo_in[QW-2:0], fits};

        always_ff @(posedge aclk) begin
            if (en) begin
                div_rem_reg[i] <= rem_next;
                div_quo_reg[i] <= quo_next;
                div_car_reg[i] <= car_in;
            end
        end
    end

    // ---------------- stage H: h and y - x ----------------
    carry_t               div_out;
    logic [HW-1:0]        sh_h_reg, sh_h_next;
    logic signed [DW-1:0] sh_d_reg, sh_d_next;
    carry_t               sh_car_reg;

    assign div_out   = div_car_reg[DIV_STAGES-1];
    assign sh_h_next = div_out.e_neg ? HALF_H - {2'b00, div_quo_reg[DIV_STAGES-1]}
                                     : HALF_H + {2'b00, div_quo_reg[DIV_STAGES-1]};
    assign sh_d_next = DW'($signed(div_out.y)) - DW'($signed(div_out.x));

    always_ff @(posedge aclk) begin
        if (en) begin
            sh_h_reg   <= sh_h_next;
            sh_d_reg   <= sh_d_next;
            sh_car_reg <= div_out;
        end
    end

    // ---------------- stage M: (y-x)*h and h*(1-h) ----------------
    logic signed [HW:0]   h_s;
    logic signed [PW-1:0] sm_prod_reg, sm_prod_next;
    logic [2*HW-1:0]      hh;
    logic [PBW-1:0]       sm_p_reg, sm_p_next;
    carry_t               sm_car_reg;

    assign h_s          = $signed({1'b0, sh_h_reg});
    assign sm_prod_next = sh_d_reg * h_s;
    assign hh           = sh_h_reg * (ONE_H - sh_h_reg);
    assign sm_p_next    = hh[F +: PBW];

    always_ff @(posedge aclk) begin
        if (en) begin
            sm_prod_reg <= sm_prod_next;
            sm_p_reg    <= sm_p_next;
            sm_car_reg  <= sh_car_reg;
        end
    end

    // ---------------- stage N: mix and k*p ----------------
    logic signed [PW-1:0] prod_sh;
    logic signed [DW-1:0] sn_m_reg, sn_m_next;
    logic [KPW-1:0]       sn_kp_reg, sn_kp_next;
    carry_t               sn_car_reg;

    // arithmetic shift gives the floor for negative products
    assign prod_sh    = sm_prod_reg >>> F;
    assign sn_m_next  = DW'($signed(sm_car_reg.x)) + $signed(prod_sh[DW-1:0]);
    assign sn_kp_next = k_reg * sm_p_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sn_m_reg   <= sn_m_next;
            sn_kp_reg  <= sn_kp_next;
            sn_car_reg <= sm_car_reg;
        end
    end

    // ---------------- output: bump, select, saturate ----------------
    logic [BW-1:0]        bump;
    logic signed [SW-1:0] bump_s, m_s, res;
    logic signed [W-1:0]  out_reg, out_next;

    assign bump   = sn_kp_reg[KPW-1:F];
    assign bump_s = $signed(SW'(bump));
    assign m_s    = SW'(sn_m_reg);

    always_comb begin
        if (!sn_car_reg.blend) begin
            res = SW'($signed(sn_car_reg.v));
        end else if (sn_car_reg.add_bump) begin
            res = m_s + bump_s;
        end else begin
            res = m_s - bump_s;
        end
        priority if (res > SAT_MAX) begin
            out_next = SAT_MAX[W-1:0];
        end else if (res < SAT_MIN) begin
            out_next = SAT_MIN[W-1:0];
        end else begin
            out_next = res[W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign m_dist_out = out_reg;

`ifndef SYNTHESIS
    // hard operations never take the blend path
    a_hard_no_blend: assert property (@(posedge aclk) disable iff (!aresetn)
        en && s1_vld_reg && !s1_smooth_reg |=> s2_vld_reg && !s2_car_reg.blend)
        else $error("hard operation routed to blend");

    // h lies strictly inside (0, 1) whenever a blend is in progress
    a_h_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sh_vld_reg && sh_car_reg.blend |-> (sh_h_reg != '0) && (sh_h_reg < ONE_H))
        else $error("blend weight out of range");

    // a stall freezes the inner stages
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(s2_vld_reg) && $stable(div_vld_reg) && $stable(sn_vld_reg)
                && $stable(sn_m_reg))
        else $error("pipeline moved during stall");

    // an input transfer always lands in the first stage
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> s1_vld_reg)
        else $error("accepted item lost at entry");
`endif

endmodule

/* tb/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sdfcsg_pkg::*;

    localparam int     WORD_BITS    = 32;
    localparam int     FRAC_BITS    = 16;
    localparam int     CLK_PERIOD   = 20;
    localparam int     RESET_CYCLES = 4;
    localparam int     FLUSH_CYCLES = 40;
    localparam int     CYCLE_LIMIT  = 200000;
    localparam int     N_SEGMENTS   = 16;
    localparam int     SEG_PAIRS    = 34;

    localparam longint UNIT_Q   = longint'(1) << FRAC_BITS;
    localparam longint HALF_Q   = UNIT_Q >> 1;
    localparam longint DIST_MAX = 64'sd2147483647;
    localparam longint DIST_MIN = -64'sd2147483648;

    localparam logic signed [WORD_BITS-1:0] D_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_BITS-1:0] D_MIN = 32'sh8000_0000;
    localparam logic signed [WORD_BITS-1:0] D_ONE = 32'sh0001_0000;

    // codes outside the enum; the block treats them as hard intersect
    localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_IDX_LAST = '1;

    localparam logic [CFG_DATA_W-1:0] K_WORD_ZERO = 32'h0000_0000;
    localparam logic [CFG_DATA_W-1:0] K_WORD_FULL = 32'hFFFF_FFFF;
    localparam logic [CFG_DATA_W-1:0] K_WORD_UNIT = {1'b0, K_RESET};

    typedef struct {
        logic signed [WORD_BITS-1:0] a;
        logic signed [WORD_BITS-1:0] b;
        logic [OP_W-1:0]             op;
        logic [K_BITS-1:0]           k;
        logic signed [WORD_BITS-1:0] dist_exp;
    } combined_dist_t;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [CFG_IDX_W-1:0]          cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]         cfg_data  = '0;
    logic                          s_valid   = 1'b0;
    logic                          s_ready;
    logic signed [WORD_BITS-1:0]   s_dist_a  = '0;
    logic signed [WORD_BITS-1:0]   s_dist_b  = '0;
    logic                          m_valid;
    logic                          m_ready   = 1'b0;
    logic signed [WORD_BITS-1:0]   m_dist_out;

    // shadow of the block's registers, updated on each cfg transfer
    logic [OP_W-1:0]   cur_op = OP_INTERSECT;
    logic [K_BITS-1:0] cur_k  = K_RESET;

    combined_dist_t pending_dist_q[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int n_pairs        = 0;
    int n_checked      = 0;
    int n_settings     = 0;
    int n_errors       = 0;
    int cycle_count    = 0;

    sdf_csg_smooth_combiner_core #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_dist_a   (s_dist_a),
        .s_dist_b   (s_dist_b),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_dist_out (m_dist_out)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles, %0d results outstanding",
                     cycle_count, pending_dist_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // polynomial smooth-min blend between x (h = 0) and y (h = 1)
    function automatic longint poly_blend(input longint x, input longint y, input longint e,
                                          input longint k, input bit add_bump);
        longint mag, t, h, m, p, bump;
        if (e >= k)
            return y;
        if (e <= -k)
            return x;
        mag  = (e < 0) ? -e : e;
        t    = (mag * UNIT_Q) / (2 * k);
        h    = (e >= 0) ? HALF_Q + t : HALF_Q - t;
        m    = x + (((y - x) * h) >>> FRAC_BITS);
        p    = (h * (UNIT_Q - h)) >>> FRAC_BITS;
        bump = (k * p) >>> FRAC_BITS;
        return add_bump ? m + bump : m - bump;
    endfunction

    function automatic logic signed [WORD_BITS-1:0] combine_dist(
            input logic signed [WORD_BITS-1:0] a, input logic signed [WORD_BITS-1:0] b,
            input logic [OP_W-1:0] op, input logic [K_BITS-1:0] k_reg);
        longint sa, sb, kk, r;
        sa = a;
        sb = b;
        kk = k_reg;
        if (kk == 0)
            kk = 1;
        case (op)
            OP_UNION:             r = (sa < sb) ? sa : sb;
            OP_DIFFERENCE:        r = (sa > -sb) ? sa : -sb;
            OP_SMOOTH_INTERSECT:  r = poly_blend(sa, sb, sb - sa, kk, 1'b1);
            OP_SMOOTH_UNION:      r = poly_blend(sa, sb, sa - sb, kk, 1'b0);
            OP_SMOOTH_DIFFERENCE: r = poly_blend(sa, -sb, -(sa + sb), kk, 1'b1);
            default:              r = (sa > sb) ? sa : sb;
        endcase
        if (r > DIST_MAX)
            r = DIST_MAX;
        else if (r < DIST_MIN)
            r = DIST_MIN;
        return r[WORD_BITS-1:0];
    endfunction

    always @(posedge aclk) begin
        combined_dist_t exp_item;
        if (aresetn && m_valid && m_ready) begin
            if (pending_dist_q.size() == 0) begin
                $error("dist_out: unexpected result %0d with nothing outstanding", m_dist_out);
                n_errors++;
            end else begin
                exp_item = pending_dist_q.pop_front();
                n_checked++;
                if (m_dist_out !== exp_item.dist_exp) begin
                    $error("dist_out: expected %0d, actual %0d (op %0d k %0d a %0d b %0d)",
                           exp_item.dist_exp, m_dist_out, exp_item.op, exp_item.k,
                           exp_item.a, exp_item.b);
                    n_errors++;
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_COMBINE_OP)
            cur_op = data[OP_W-1:0];
        else if (idx == REG_SMOOTH_K)
            cur_k = data[K_BITS-1:0];
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // valid is only dropped when a gap is taken, so back-to-back pairs keep it high
    task automatic send_pair(input logic signed [WORD_BITS-1:0] a,
                             input logic signed [WORD_BITS-1:0] b);
        combined_dist_t exp_item;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid  <= 1'b1;
        s_dist_a <= a;
        s_dist_b <= b;
        do @(posedge aclk); while (!s_ready);
        exp_item.a        = a;
        exp_item.b        = b;
        exp_item.op       = cur_op;
        exp_item.k        = cur_k;
        exp_item.dist_exp = combine_dist(a, b, cur_op, cur_k);
        pending_dist_q.push_back(exp_item);
        n_pairs++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_dist_q.size() != 0);
    endtask

    task automatic apply_setting(input logic [CFG_DATA_W-1:0] op_word,
                                 input logic [CFG_DATA_W-1:0] k_word);
        wait_idle();
        write_reg(REG_COMBINE_OP, op_word);
        write_reg(REG_SMOOTH_K, k_word);
        n_settings++;
    endtask

    function automatic logic signed [WORD_BITS-1:0] pick_dist();
        case ($urandom_range(5))
            0: begin
                case ($urandom_range(3))
                    0: return D_MAX;
                    1: return D_MIN;
                    2: return '0;
                    default: return -1;
                endcase
            end
            1, 2: return $urandom();
            default: return $urandom_range(32'h0010_0000) - 32'h0008_0000;
        endcase
    endfunction

    // partner distance that lands inside (or just outside) the blend band
    function automatic logic signed [WORD_BITS-1:0] near_partner(
            input logic signed [WORD_BITS-1:0] a);
        longint     span, off;
        logic [63:0] r;
        span = (cur_k == 0) ? 2 : 2 * longint'(cur_k);
        r    = {$urandom(), $urandom()};
        r    = r % (2 * span + 1);
        off  = $signed(r) - span;
        if (cur_op == OP_SMOOTH_DIFFERENCE)
            return 32'(off - longint'(a));
        return 32'(longint'(a) + off);
    endfunction

    task automatic test_reset_values();
        send_pair(D_MAX, D_MIN);
        send_pair(D_MIN, -1);
    endtask

    task automatic test_hard_ops();
        apply_setting({29'd0, OP_UNION}, K_WORD_UNIT);
        send_pair(D_MIN, D_MAX);
        send_pair(-1, 0);
        apply_setting({29'd0, OP_DIFFERENCE}, K_WORD_UNIT);
        send_pair(5 * D_ONE, D_MIN);    // -B overflows the word, must saturate
        send_pair(D_MIN, D_MAX);
        send_pair(0, 1);
        // spare codes, upper data bits set and ignored
        apply_setting({29'h1FFF_FFFF, OP_UNUSED_6}, K_WORD_UNIT);
        send_pair(1, 2);
        apply_setting({29'h0AAA_AAAA, OP_UNUSED_7}, K_WORD_UNIT);
        send_pair(-5, -3);
    endtask

    task automatic test_smooth_ops();
        apply_setting({29'd0, OP_SMOOTH_INTERSECT}, K_WORD_UNIT);
        send_pair(0, 0);
        send_pair(D_ONE, 0);
        send_pair(0, D_ONE);
        send_pair(D_ONE / 2, 0);
        apply_setting({29'd0, OP_SMOOTH_UNION}, K_WORD_UNIT | 32'h8000_0000);
        send_pair(D_ONE / 2, 0);
        send_pair(0, D_ONE - 1);
        apply_setting({29'd0, OP_SMOOTH_DIFFERENCE}, K_WORD_UNIT);
        send_pair(D_ONE / 4, D_ONE / 4);
        send_pair(0, D_MIN);
    endtask

    task automatic test_blend_width_edges();
        apply_setting({29'd0, OP_SMOOTH_UNION}, K_WORD_ZERO);
        send_pair(1, 0);
        send_pair(0, 0);
        apply_setting({29'd0, OP_SMOOTH_UNION}, K_WORD_FULL);
        // writes to unmapped indexes must leave both registers alone
        write_reg(REG_IDX_LAST, $urandom());
        write_reg(CFG_IDX_W'(REG_SMOOTH_K + 1), $urandom());
        send_pair(D_MAX, D_MIN);
        send_pair(D_MIN, D_MIN);
        apply_setting({29'd0, OP_SMOOTH_INTERSECT}, K_WORD_FULL);
        send_pair(D_MAX, D_MAX);
        apply_setting({29'd0, OP_SMOOTH_DIFFERENCE}, K_WORD_FULL);
        send_pair(D_MIN, D_MAX);
    endtask

    task automatic test_random_streams();
        logic [CFG_DATA_W-1:0]       op_word, k_word;
        logic signed [WORD_BITS-1:0] a, b;
        for (int seg = 0; seg < N_SEGMENTS; seg++) begin
            op_word = $urandom();
            op_word[OP_W-1:0] = (seg < 8) ? seg[OP_W-1:0] : OP_W'($urandom_range(7));
            case (seg % 4)
                0: k_word = $urandom_range(32'h0002_0000, 1) | ($urandom() & 32'h8000_0000);
                1: k_word = $urandom_range(32'h0100_0000, 32'h0002_0000);
                2: k_word = $urandom();
                default: k_word = $urandom_range(1) ? K_WORD_FULL : 32'h8000_0000;
            endcase
            apply_setting(op_word, k_word);
            write_reg(CFG_IDX_W'($urandom_range(REG_IDX_LAST, REG_SMOOTH_K + 1)), $urandom());
            case ((seg / 2) % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            for (int i = 0; i < SEG_PAIRS; i++) begin
                a = pick_dist();
                b = $urandom_range(1) ? near_partner(a) : pick_dist();
                send_pair(a, b);
            end
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_values();
        test_hard_ops();
        test_smooth_ops();
        test_blend_width_edges();
        test_random_streams();
        wait_idle();
        repeat (FLUSH_CYCLES) @(posedge aclk);
        $display("Checked %0d combined distances from %0d pairs over %0d register settings,",
                 n_checked, n_pairs, n_settings);
        $display("all eight op codes, zero and full-scale k, saturation and mixed stalls.");
        if (n_errors == 0 && pending_dist_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* files.f */
sv/sdfcsg_pkg.sv
sv/sdf_csg_smooth_combiner_core.sv
tb/tb_top.sv
